// ----- design/rdfd_pkg.sv -----
// ----------------------------------------------------------------------------
// rdfd_pkg: shared definitions for the run duration frame decoder
// Widths, frame geometry, register codes and the command passed from the
// classifying front end to the frame assembly back end.
// ----------------------------------------------------------------------------
package rdfd_pkg;

  localparam int FRAME_BITS  = 11;
  localparam int MAX_FRAMES  = 16;
  localparam int PAYLOAD_W   = 9;
  localparam int DUR_W       = 16;
  localparam int BP_W        = 12;
  localparam int FP_W        = 16;
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = 16;
  localparam int QUEUE_DEPTH = 4;

  localparam int CNT_W    = $clog2(FRAME_BITS + 1);
  localparam int ADDR_W   = $clog2(MAX_FRAMES);
  localparam int STORED_W = $clog2(MAX_FRAMES + 1);
  localparam int STEP_W   = $clog2(DUR_W);

  localparam logic [BP_W-1:0] BP_RESET = BP_W'(208);
  localparam logic [FP_W-1:0] FP_RESET = FP_W'(2291);

  localparam logic [CFG_IDX_W-1:0] CFG_BIT_PERIOD   = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_PERIOD = CFG_IDX_W'(1);

  typedef struct packed {
    logic             is_end;
    logic [CNT_W-1:0] count;
  } cmd_t;

endpackage

// ----- design/run_duration_frame_decoder.sv -----
// ----------------------------------------------------------------------------
// run_duration_frame_decoder: 9-bit serial frame decoder fed with run lengths
// A normal run goes through the front end's 16-step restoring divider;
// an end run skips it. The back end applies each run from its queue. An end
// run yields one error result or the stored payloads, one store read each.
// Synchronous active-low reset clears control state and restores the
// registers; the frame store is not cleared.
// ----------------------------------------------------------------------------
module run_duration_frame_decoder (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [rdfd_pkg::DUR_W-1:0]         in_run_duration_us,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [rdfd_pkg::PAYLOAD_W-1:0]     out_payload,
  output logic                               out_last_of_datagram,
  output logic                               out_frame_error,
  input  logic                               cfg_we,
  input  logic [rdfd_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [rdfd_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

  logic [rdfd_pkg::BP_W-1:0] bit_period_r;
  logic [rdfd_pkg::FP_W-1:0] frame_period_r;

  logic           f_cmd_valid, f_cmd_ready;
  rdfd_pkg::cmd_t f_cmd;
  logic           q_cmd_valid, q_cmd_ready;
  rdfd_pkg::cmd_t q_cmd;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bit_period_r   <= rdfd_pkg::BP_RESET;
      frame_period_r <= rdfd_pkg::FP_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        rdfd_pkg::CFG_BIT_PERIOD:   bit_period_r   <= cfg_wdata[rdfd_pkg::BP_W-1:0];
        rdfd_pkg::CFG_FRAME_PERIOD: frame_period_r <= cfg_wdata[rdfd_pkg::FP_W-1:0];
        default: ;
      endcase
    end
  end

  rdfd_front u_front (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_run_duration_us (in_run_duration_us),
    .bit_period_us      (bit_period_r),
    .frame_period_us    (frame_period_r),
    .cmd_valid          (f_cmd_valid),
    .cmd_ready          (f_cmd_ready),
    .cmd                (f_cmd)
  );

  rdfd_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (f_cmd_valid),
    .push_ready (f_cmd_ready),
    .push_cmd   (f_cmd),
    .pop_valid  (q_cmd_valid),
    .pop_ready  (q_cmd_ready),
    .pop_cmd    (q_cmd)
  );

  rdfd_back u_back (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cmd_valid            (q_cmd_valid),
    .cmd_ready            (q_cmd_ready),
    .cmd                  (q_cmd),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_payload          (out_payload),
    .out_last_of_datagram (out_last_of_datagram),
    .out_frame_error      (out_frame_error)
  );

endmodule

// ----- design/rdfd_ram.sv -----
// ----------------------------------------------------------------------------
// rdfd_ram: generic single write port RAM
// One write and one read port, read data registered on read enable.
// ----------------------------------------------------------------------------
module rdfd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- design/rdfd_front.sv -----
// ----------------------------------------------------------------------------
// rdfd_front: run classifier and bit count divider
// Accepts run durations, flags end runs and turns other runs into a rounded,
// clamped bit count through a one bit per cycle restoring divider.
// ----------------------------------------------------------------------------
module rdfd_front (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [rdfd_pkg::DUR_W-1:0]    in_run_duration_us,
  input  logic [rdfd_pkg::BP_W-1:0]     bit_period_us,
  input  logic [rdfd_pkg::FP_W-1:0]     frame_period_us,
  output logic                          cmd_valid,
  input  logic                          cmd_ready,
  output rdfd_pkg::cmd_t                cmd
);

  typedef enum logic [1:0] {F_IDLE, F_DIV, F_PUSH} state_t;

  state_t                         state_r, state_nxt;
  logic                           is_end_r, is_end_nxt;
  logic [rdfd_pkg::BP_W-1:0]      bp_r, bp_nxt;
  logic [rdfd_pkg::BP_W-1:0]      rem_r, rem_nxt;
  logic [rdfd_pkg::DUR_W-1:0]     dvd_r, dvd_nxt;
  logic [rdfd_pkg::DUR_W-1:0]     q_r, q_nxt;
  logic [rdfd_pkg::STEP_W-1:0]    step_r, step_nxt;

  logic [rdfd_pkg::BP_W:0]        trial;
  logic                           take;
  logic                           round_up;
  logic [rdfd_pkg::DUR_W:0]       count_sum;
  logic [rdfd_pkg::CNT_W-1:0]     count_sat;

  assign trial     = {rem_r, dvd_r[rdfd_pkg::DUR_W-1]};
  assign take      = trial >= {1'b0, bp_r};
  assign round_up  = rem_r >= (bp_r >> 1);
  assign count_sum = {1'b0, q_r} + (rdfd_pkg::DUR_W + 1)'(round_up);
  assign count_sat = (count_sum > (rdfd_pkg::DUR_W + 1)'(rdfd_pkg::FRAME_BITS)) ?
                     rdfd_pkg::CNT_W'(rdfd_pkg::FRAME_BITS) :
                     count_sum[rdfd_pkg::CNT_W-1:0];

  assign in_ready     = (state_r == F_IDLE);
  assign cmd_valid    = (state_r == F_PUSH);
  assign cmd.is_end   = is_end_r;
  assign cmd.count    = is_end_r ? '0 : count_sat;

  always_comb begin
    state_nxt  = state_r;
    is_end_nxt = is_end_r;
    bp_nxt     = bp_r;
    rem_nxt    = rem_r;
    dvd_nxt    = dvd_r;
    q_nxt      = q_r;
    step_nxt   = step_r;
    case (state_r)
      F_IDLE: begin
        if (in_valid) begin
          is_end_nxt = (in_run_duration_us >= frame_period_us);
          bp_nxt     = (bit_period_us == '0) ? rdfd_pkg::BP_W'(1) : bit_period_us;
          rem_nxt    = '0;
          dvd_nxt    = in_run_duration_us;
          q_nxt      = '0;
          step_nxt   = '0;
          state_nxt  = (in_run_duration_us >= frame_period_us) ? F_PUSH : F_DIV;
        end
      end
      F_DIV: begin
        rem_nxt  = take ? rdfd_pkg::BP_W'(trial - {1'b0, bp_r}) :
                          trial[rdfd_pkg::BP_W-1:0];
        dvd_nxt  = {dvd_r[rdfd_pkg::DUR_W-2:0], 1'b0};
        q_nxt    = {q_r[rdfd_pkg::DUR_W-2:0], take};
        step_nxt = step_r + rdfd_pkg::STEP_W'(1);
        if (step_r == rdfd_pkg::STEP_W'(rdfd_pkg::DUR_W - 1)) begin
          state_nxt = F_PUSH;
        end
      end
      F_PUSH: begin
        if (cmd_ready) begin
          state_nxt = F_IDLE;
        end
      end
      default: state_nxt = F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    is_end_r <= is_end_nxt;
    bp_r     <= bp_nxt;
    rem_r    <= rem_nxt;
    dvd_r    <= dvd_nxt;
    q_r      <= q_nxt;
    step_r   <= step_nxt;
  end

endmodule

// ----- design/rdfd_queue.sv -----
// ----------------------------------------------------------------------------
// rdfd_queue: command queue between front and back
// Small register FIFO that lets the divider and the frame assembly stall
// independently.
// ----------------------------------------------------------------------------
module rdfd_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push_valid,
  output logic           push_ready,
  input  rdfd_pkg::cmd_t push_cmd,
  output logic           pop_valid,
  input  logic           pop_ready,
  output rdfd_pkg::cmd_t pop_cmd
);

  localparam int PTR_W = $clog2(rdfd_pkg::QUEUE_DEPTH);

  rdfd_pkg::cmd_t    slot_r [rdfd_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [PTR_W:0]    fill_r, fill_nxt;
  logic              do_push, do_pop;

  assign push_ready = (fill_r != (PTR_W + 1)'(rdfd_pkg::QUEUE_DEPTH));
  assign pop_valid  = (fill_r != '0);
  assign pop_cmd    = slot_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + PTR_W'(1) : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + PTR_W'(1) : rd_ptr_r;
    fill_nxt   = fill_r;
    if (do_push && !do_pop) begin
      fill_nxt = fill_r + (PTR_W + 1)'(1);
    end else if (do_pop && !do_push) begin
      fill_nxt = fill_r - (PTR_W + 1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

// ----- design/rdfd_back.sv -----
// ----------------------------------------------------------------------------
// rdfd_back: frame assembly and datagram emission
// Shifts bit counts into the current frame, checks and stores finished
// frames, and on an end run emits the stored payloads or one error result.
// ----------------------------------------------------------------------------
module rdfd_back (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cmd_valid,
  output logic                            cmd_ready,
  input  rdfd_pkg::cmd_t                  cmd,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [rdfd_pkg::PAYLOAD_W-1:0]  out_payload,
  output logic                            out_last_of_datagram,
  output logic                            out_frame_error
);

  typedef enum logic [2:0] {B_IDLE, B_END, B_ERR, B_READ, B_LOAD} state_t;

  localparam int SUM_W = rdfd_pkg::CNT_W + 1;

  state_t                              state_r, state_nxt;
  logic [rdfd_pkg::CNT_W-1:0]          bits_r, bits_nxt;
  logic                                level_r, level_nxt;
  logic [rdfd_pkg::FRAME_BITS-1:0]     shift_r, shift_nxt;
  logic [rdfd_pkg::STORED_W-1:0]       stored_r, stored_nxt;
  logic                                bad_r, bad_nxt;
  logic [rdfd_pkg::ADDR_W-1:0]         idx_r, idx_nxt;
  logic                                out_valid_r, out_valid_nxt;
  logic [rdfd_pkg::PAYLOAD_W-1:0]      payload_r, payload_nxt;
  logic                                last_r, last_nxt;
  logic                                err_r, err_nxt;

  logic [rdfd_pkg::CNT_W-1:0]          eff_count;
  logic [SUM_W-1:0]                    bit_sum;
  logic [rdfd_pkg::FRAME_BITS-1:0]     fill_mask;
  logic [rdfd_pkg::FRAME_BITS-1:0]     shift_filled;
  logic                                frame_full;
  logic                                store_room;
  logic                                frame_ok;
  logic                                ram_we;
  logic                                ram_re;
  logic [rdfd_pkg::PAYLOAD_W-1:0]      ram_rdata;
  logic                                out_free;
  logic                                idx_last;

  assign eff_count = cmd.is_end ?
                     ((bits_r != '0) ? rdfd_pkg::CNT_W'(rdfd_pkg::FRAME_BITS) : '0) :
                     cmd.count;
  assign bit_sum   = {1'b0, bits_r} + {1'b0, eff_count};

  always_comb begin
    for (int i = 0; i < rdfd_pkg::FRAME_BITS; i++) begin
      fill_mask[i] = (SUM_W'(i) >= {1'b0, bits_r}) && (SUM_W'(i) < bit_sum);
    end
  end

  assign shift_filled = level_r ? (shift_r | fill_mask) : shift_r;
  assign frame_full   = bit_sum >= SUM_W'(rdfd_pkg::FRAME_BITS);
  assign store_room   = stored_r < rdfd_pkg::STORED_W'(rdfd_pkg::MAX_FRAMES);
  assign frame_ok     = !shift_filled[0] && shift_filled[rdfd_pkg::FRAME_BITS-1];
  assign cmd_ready    = (state_r == B_IDLE);
  assign ram_we       = cmd_valid && cmd_ready && frame_full && store_room;
  assign ram_re       = (state_r == B_READ);
  assign out_free     = !out_valid_r || out_ready;
  assign idx_last     = ({1'b0, idx_r} + rdfd_pkg::STORED_W'(1)) == stored_r;

  rdfd_ram #(
    .WIDTH (rdfd_pkg::PAYLOAD_W),
    .DEPTH (rdfd_pkg::MAX_FRAMES)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (stored_r[rdfd_pkg::ADDR_W-1:0]),
    .wdata (rdfd_pkg::PAYLOAD_W'(shift_filled >> 1)),
    .re    (ram_re),
    .raddr (idx_r),
    .rdata (ram_rdata)
  );

  always_comb begin
    state_nxt     = state_r;
    bits_nxt      = bits_r;
    level_nxt     = level_r;
    shift_nxt     = shift_r;
    stored_nxt    = stored_r;
    bad_nxt       = bad_r;
    idx_nxt       = idx_r;
    out_valid_nxt = out_valid_r && !out_ready;
    payload_nxt   = payload_r;
    last_nxt      = last_r;
    err_nxt       = err_r;
    case (state_r)
      B_IDLE: begin
        if (cmd_valid) begin
          if (frame_full) begin
            if (store_room) begin
              bad_nxt    = bad_r || !frame_ok;
              stored_nxt = stored_r + rdfd_pkg::STORED_W'(1);
            end
            bits_nxt  = '0;
            level_nxt = 1'b0;
            shift_nxt = '0;
          end else begin
            bits_nxt  = bit_sum[rdfd_pkg::CNT_W-1:0];
            level_nxt = !level_r;
            shift_nxt = shift_filled;
          end
          if (cmd.is_end) begin
            state_nxt = B_END;
          end
        end
      end
      B_END: begin
        idx_nxt = '0;
        if (stored_r == '0) begin
          state_nxt = B_IDLE;
        end else if (bad_r) begin
          state_nxt = B_ERR;
        end else begin
          state_nxt = B_READ;
        end
      end
      B_ERR: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          payload_nxt   = '0;
          last_nxt      = 1'b1;
          err_nxt       = 1'b1;
          state_nxt     = B_IDLE;
        end
      end
      B_READ: begin
        state_nxt = B_LOAD;
      end
      B_LOAD: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          payload_nxt   = ram_rdata;
          last_nxt      = idx_last;
          err_nxt       = 1'b0;
          idx_nxt       = idx_r + rdfd_pkg::ADDR_W'(1);
          state_nxt     = idx_last ? B_IDLE : B_READ;
        end
      end
      default: state_nxt = B_IDLE;
    endcase
    if (state_nxt == B_IDLE && state_r != B_IDLE) begin
      bits_nxt   = '0;
      level_nxt  = 1'b0;
      shift_nxt  = '0;
      stored_nxt = '0;
      bad_nxt    = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      bits_r      <= '0;
      level_r     <= 1'b0;
      shift_r     <= '0;
      stored_r    <= '0;
      bad_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      bits_r      <= bits_nxt;
      level_r     <= level_nxt;
      shift_r     <= shift_nxt;
      stored_r    <= stored_nxt;
      bad_r       <= bad_nxt;
      out_valid_r <= out_valid_nxt;
    end
    idx_r     <= idx_nxt;
    payload_r <= payload_nxt;
    last_r    <= last_nxt;
    err_r     <= err_nxt;
  end

  assign out_valid            = out_valid_r;
  assign out_payload          = payload_r;
  assign out_last_of_datagram = last_r;
  assign out_frame_error      = err_r;

endmodule

// ----- dv/tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: run duration frame decoder testbench
// Feeds run lengths over a valid/ready channel and predicts the 9-bit payloads
// or error results of each datagram. A scoreboard holds its own decoder state
// and checks every result transaction in order. Register settings change
// between phases while the block is idle. Sender bursts and receiver stalls
// are random.
// ----------------------------------------------------------------------------
module tb;

  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned ITEM_TARGET = 320;

  typedef struct packed {
    logic [rdfd_pkg::PAYLOAD_W-1:0] payload;
    logic                           is_last;
    logic                           err;
  } frame_result_t;

  class datagram_tracker;
    int unsigned                     bit_period;
    int unsigned                     frame_period;
    int unsigned                     bits_in;
    int unsigned                     kept;
    bit                              level;
    bit                              bad;
    logic [rdfd_pkg::FRAME_BITS-1:0] shift_reg;
    logic [rdfd_pkg::PAYLOAD_W-1:0]  store [rdfd_pkg::MAX_FRAMES];
    frame_result_t                   pending [$];
    int unsigned                     mismatches;

    function new();
      bit_period   = rdfd_pkg::BP_RESET;
      frame_period = rdfd_pkg::FP_RESET;
      mismatches   = 0;
      clear_frame();
      kept = 0;
      bad  = 0;
    endfunction

    function void clear_frame();
      bits_in   = 0;
      level     = 0;
      shift_reg = '0;
    endfunction

    function void shift_in(int unsigned cnt);
      for (int unsigned i = 0; i < cnt && bits_in < rdfd_pkg::FRAME_BITS; i++) begin
        if (level) shift_reg[bits_in] = 1'b1;
        bits_in++;
      end
    endfunction

    function void close_frame();
      if (kept < rdfd_pkg::MAX_FRAMES) begin
        if (shift_reg[0] || !shift_reg[rdfd_pkg::FRAME_BITS-1]) bad = 1;
        store[kept] = shift_reg[rdfd_pkg::PAYLOAD_W:1];
        kept++;
      end
      clear_frame();
    endfunction

    function void note_run(logic [rdfd_pkg::DUR_W-1:0] dur);
      int unsigned   bp;
      int unsigned   cnt;
      int unsigned   room;
      frame_result_t r;
      if (dur >= frame_period) begin
        if (bits_in > 0) begin
          shift_in(rdfd_pkg::FRAME_BITS);
          close_frame();
        end
        if (kept > 0) begin
          if (bad) begin
            r = '{payload: '0, is_last: 1'b1, err: 1'b1};
            pending.push_back(r);
          end else begin
            for (int unsigned i = 0; i < kept; i++) begin
              r = '{payload: store[i], is_last: (i + 1 == kept), err: 1'b0};
              pending.push_back(r);
            end
          end
        end
        clear_frame();
        kept = 0;
        bad  = 0;
        return;
      end
      bp  = (bit_period == 0) ? 1 : bit_period;
      cnt = dur / bp;
      if (dur % bp >= bp / 2) cnt++;
      room = rdfd_pkg::FRAME_BITS - bits_in;
      if (cnt > room) cnt = room;
      shift_in(cnt);
      if (bits_in >= rdfd_pkg::FRAME_BITS) close_frame();
      else level = ~level;
    endfunction

    function void check_result(logic [rdfd_pkg::PAYLOAD_W-1:0] payload, logic is_last,
                               logic err);
      frame_result_t exp_r;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result payload %h last %b error %b",
                 $time, payload, is_last, err);
        mismatches++;
        return;
      end
      exp_r = pending.pop_front();
      if (payload !== exp_r.payload) begin
        $display("%0t: payload expected %h actual %h", $time, exp_r.payload, payload);
        mismatches++;
      end
      if (is_last !== exp_r.is_last) begin
        $display("%0t: last_of_datagram expected %b actual %b", $time, exp_r.is_last,
                 is_last);
        mismatches++;
      end
      if (err !== exp_r.err) begin
        $display("%0t: frame_error expected %b actual %b", $time, exp_r.err, err);
        mismatches++;
      end
    endfunction

    function int unsigned outstanding();
      return pending.size();
    endfunction
  endclass

  logic                            clk = 1'b0;
  logic                            rst_n = 1'b0;
  logic                            in_valid = 1'b0;
  logic                            in_ready;
  logic [rdfd_pkg::DUR_W-1:0]      in_run_duration_us = '0;
  logic                            out_valid;
  logic                            out_ready = 1'b0;
  logic [rdfd_pkg::PAYLOAD_W-1:0]  out_payload;
  logic                            out_last_of_datagram;
  logic                            out_frame_error;
  logic                            cfg_we = 1'b0;
  logic [rdfd_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [rdfd_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;

  datagram_tracker tracker;
  logic [31:0]     cyc = '0;
  logic [1:0]      rdy_mode = '0;
  int unsigned     items_sent = 0;
  int unsigned     burst_left = 0;
  int unsigned     dg_count = 0;
  int unsigned     cur_bp = rdfd_pkg::BP_RESET;
  int unsigned     cur_fp = rdfd_pkg::FP_RESET;
  logic [rdfd_pkg::DUR_W-1:0] run_plan [$];

  run_duration_frame_decoder u_dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_ready             (in_ready),
    .in_run_duration_us   (in_run_duration_us),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_payload          (out_payload),
    .out_last_of_datagram (out_last_of_datagram),
    .out_frame_error      (out_frame_error),
    .cfg_we               (cfg_we),
    .cfg_index            (cfg_index),
    .cfg_wdata            (cfg_wdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cyc <= cyc + 1;
    if (cyc[5:0] == 6'd0) rdy_mode <= 2'($urandom_range(0, 3));
    case (rdy_mode)
      2'd0: out_ready <= 1'b1;
      2'd1: out_ready <= 1'($urandom_range(0, 1));
      2'd2: out_ready <= ($urandom_range(0, 3) == 0);
      default: out_ready <= cyc[3];
    endcase
    if (cyc >= CYCLE_LIMIT) begin
      $display("run_duration_frame_decoder: mismatch");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      tracker.check_result(out_payload, out_last_of_datagram, out_frame_error);
    end
  end

  task automatic send_run(input int unsigned d);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    in_run_duration_us <= rdfd_pkg::DUR_W'(d);
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    tracker.note_run(rdfd_pkg::DUR_W'(d));
    items_sent++;
  endtask

  // hold off until every result has drained, then let the pipeline empty
  task automatic settle();
    in_valid <= 1'b0;
    while (tracker.outstanding() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  task automatic write_regs(input int unsigned bp, input int unsigned fp);
    cfg_we    <= 1'b1;
    cfg_index <= rdfd_pkg::CFG_BIT_PERIOD;
    cfg_wdata <= rdfd_pkg::CFG_DATA_W'(bp);
    @(posedge clk);
    cfg_index <= rdfd_pkg::CFG_FRAME_PERIOD;
    cfg_wdata <= rdfd_pkg::CFG_DATA_W'(fp);
    @(posedge clk);
    cfg_we <= 1'b0;
    cur_bp = bp;
    cur_fp = fp;
    tracker.bit_period   = bp;
    tracker.frame_period = fp;
  endtask

  function automatic int unsigned fit_run(longint d);
    if (d > 65535) d = 65535;
    if (d >= cur_fp) d = (cur_fp == 0) ? 0 : cur_fp - 1;
    return int'(d);
  endfunction

  function automatic int unsigned pick_end();
    case ($urandom_range(0, 3))
      0: return cur_fp;
      1: return 65535;
      default: return $urandom_range(cur_fp, 65535);
    endcase
  endfunction

  // split one frame into alternating runs, starting low
  function automatic void plan_frame(logic [rdfd_pkg::PAYLOAD_W-1:0] data, bit bad_start,
                                     bit bad_stop, bit open_tail);
    logic [rdfd_pkg::FRAME_BITS-1:0] vec;
    int unsigned bp;
    int unsigned idx;
    int unsigned n;
    int unsigned extra;
    longint      d;
    bit          lvl;
    bp  = (cur_bp == 0) ? 1 : cur_bp;
    vec = {~bad_stop, data, bad_start};
    idx = 0;
    lvl = 1'b0;
    while (idx < rdfd_pkg::FRAME_BITS) begin
      n = 0;
      while (idx + n < rdfd_pkg::FRAME_BITS && vec[idx + n] == lvl) n++;
      if (idx + n == rdfd_pkg::FRAME_BITS && open_tail) break;
      extra = (idx + n == rdfd_pkg::FRAME_BITS) ? $urandom_range(0, 2) : 0;
      if (n == 0) begin
        d = (bp / 2 > 0) ? $urandom_range(0, bp / 2 - 1) : 0;
      end else begin
        d = longint'(n + extra) * bp - (bp - bp / 2) + $urandom_range(0, bp - 1);
      end
      run_plan.push_back(rdfd_pkg::DUR_W'(fit_run(d)));
      idx += n;
      lvl = ~lvl;
    end
  endfunction

  task automatic send_frame_group();
    int unsigned                    nfr;
    bit                             open_tail;
    logic [rdfd_pkg::PAYLOAD_W-1:0] data;
    dg_count++;
    nfr = (dg_count % 12 == 5) ? $urandom_range(17, 18) : $urandom_range(1, 4);
    open_tail = 1'($urandom_range(0, 1));
    run_plan.delete();
    for (int unsigned f = 0; f < nfr; f++) begin
      case ($urandom_range(0, 7))
        0: data = '0;
        1: data = '1;
        2: data = rdfd_pkg::PAYLOAD_W'(9'h100);
        default: data = rdfd_pkg::PAYLOAD_W'($urandom_range(0, 511));
      endcase
      plan_frame(data, ($urandom_range(0, 15) == 0), ($urandom_range(0, 15) == 0),
                 open_tail && (f == nfr - 1));
      if ($urandom_range(0, 19) == 0) begin
        run_plan.push_back(rdfd_pkg::DUR_W'($urandom_range(0, 65535)));
      end
    end
    run_plan.push_back(rdfd_pkg::DUR_W'(pick_end()));
    foreach (run_plan[i]) send_run(run_plan[i]);
  endtask

  task automatic send_noise();
    int unsigned n;
    int unsigned bp;
    n  = $urandom_range(1, 6);
    bp = (cur_bp == 0) ? 1 : cur_bp;
    repeat (n) begin
      case ($urandom_range(0, 9))
        0: send_run(pick_end());
        1, 2, 3, 4: send_run($urandom_range(0, 65535));
        default: send_run(fit_run($urandom_range(0, 3 * bp + 2)));
      endcase
    end
  endtask

  initial begin
    int unsigned set_bp [8];
    int unsigned set_fp [8];
    int unsigned budget;
    int unsigned start_items;
    tracker = new();
    set_bp = '{208, 2, 4095, 0, 1, 100, 3, 0};
    set_fp = '{2291, 65535, 65535, 40, 1, 1200, 50, 0};
    set_bp[7] = $urandom_range(2, 600);
    set_fp[7] = $urandom_range(13 * set_bp[7], 65535);
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // zero-length runs and empty datagrams
    send_run(0);
    send_run(65535);
    send_run(2291);
    // all-zero payload, stop bit filled by the end run
    send_run(2080);
    send_run(2291);
    // all-ones payload, then an end run outside a frame
    send_run(208);
    send_run(2080);
    send_run(65535);
    // high start bit
    send_run(0);
    send_run(2288);
    send_run(65535);
    // low stop bit
    send_run(2288);
    send_run(2291);
    // rounding edges and clamping to the frame
    send_run(311);
    send_run(312);
    send_run(103);
    send_run(104);
    send_run(2290);
    send_run(2291);
    settle();

    for (int p = 0; p < 8; p++) begin
      if (p > 0) write_regs(set_bp[p], set_fp[p]);
      budget = (set_fp[p] <= 1) ? 12 : 24;
      start_items = items_sent;
      while (items_sent - start_items < budget || (p == 7 && items_sent < ITEM_TARGET)) begin
        if ($urandom_range(0, 3) == 0 || set_fp[p] <= 1) send_noise();
        else send_frame_group();
      end
      settle();
    end

    if (tracker.mismatches == 0 && tracker.outstanding() == 0) begin
      $display("run_duration_frame_decoder: match");
    end else begin
      $display("run_duration_frame_decoder: mismatch");
    end
    $finish;
  end

endmodule
